// ===== src/tlf_pkg.sv =====
// Shared types, character codes and helpers for the text line folder.
`default_nettype none

package tlf_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CFG_W  = 6;

   // character codes
   localparam logic [BYTE_W-1:0] CH_NL = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SP = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TB = 8'h09;

   // request command codes
   localparam logic CMD_TEXT = 1'b0;
   localparam logic CMD_END  = 1'b1;

   localparam logic [CFG_W-1:0] FOLD_WIDTH_RESET = 6'd30;

   // commands from the controller, one per non-idle controller state plus the accept strobe
   typedef struct packed {
      logic take;
      logic emit;
      logic term;
      logic scan_rd;
      logic scan_chk;
   } ctl_cmd_type;

   // status from the datapath back to the controller
   typedef struct packed {
      logic go_emit;
      logic go_scan;
      logic span_issued;
      logic nl_done;
      logic scan_hit;
      logic scan_end;
   } dp_sts_type;

   function automatic logic is_blank(input logic [BYTE_W-1:0] c);
      return (c == CH_SP) || (c == CH_TB);
   endfunction

endpackage

`default_nettype wire

// ===== src/text_line_folder_top.sv =====
// Top level of the text line folder: controller, datapath and configuration port.
//
// Folds a byte stream into lines of at most fold_width columns. A text byte that does not
// complete a segment is stored in the buffer. A byte that fills the segment, a newline, or an
// end-of-text request with text held opens an emit span: the request is taken, then the
// segment buffer is read one entry per cycle through its single registered read port while
// the result side does not stall (leading blanks are read and dropped), and the closing
// newline follows the last read. When fold_width was lowered while the buffer held text,
// the first fold afterwards may search back through the segment for its last blank, passing
// through ST_SCAN_RD and ST_SCAN_CHK for each entry. The last result of each run is the newline,
// flagged by rsp_last_of_run. The csr port is always ready and must only be written while
// the block is idle.
`default_nettype none

module text_line_folder_top #(
   parameter int unsigned BUFFER_DEPTH = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_command,
   input  wire logic [tlf_pkg::BYTE_W-1:0]    req_in_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [tlf_pkg::BYTE_W-1:0]         rsp_out_byte,
   output logic                               rsp_last_of_run,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tlf_pkg::CFG_W-1:0]     csr_fold_width
);

   tlf_pkg::ctl_cmd_type cmd;
   tlf_pkg::dp_sts_type  sts;

   // accept configuration writes at any time
   assign csr_ready = 1'b1;

   tlf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tlf_dpath #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_command     (req_command),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_write       (csr_valid && csr_ready),
      .csr_fold_width  (csr_fold_width)
   );

endmodule

`default_nettype wire

// ===== src/tlf_ctrl.sv =====
// Controller state machine for the text line folder.
`default_nettype none

module tlf_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire tlf_pkg::dp_sts_type  sts,
   output tlf_pkg::ctl_cmd_type      cmd
);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_EMIT     = 5'b00010,
      ST_TERM     = 5'b00100,
      ST_SCAN_RD  = 5'b01000,
      ST_SCAN_CHK = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // decode commands from the current state
   always_comb begin
      cmd.take     = (state_ff == ST_IDLE) && req_valid;
      cmd.emit     = (state_ff == ST_EMIT);
      cmd.term     = (state_ff == ST_TERM);
      cmd.scan_rd  = (state_ff == ST_SCAN_RD);
      cmd.scan_chk = (state_ff == ST_SCAN_CHK);
      req_stall    = (state_ff != ST_IDLE);
   end

   // advance the state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (sts.go_scan) begin
                  state_in = ST_SCAN_RD;
               end else if (sts.go_emit) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (sts.span_issued) begin
               state_in = ST_TERM;
            end
         end
         ST_TERM: begin
            if (sts.nl_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (sts.scan_hit || sts.scan_end) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/tlf_dpath.sv =====
// Datapath for the text line folder: segment ring buffer, blank tracking, read pipe, output register.
`default_nettype none

module tlf_dpath #(
   parameter int unsigned BUFFER_DEPTH = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tlf_pkg::ctl_cmd_type          cmd,
   output tlf_pkg::dp_sts_type                sts,
   input  wire logic                          req_command,
   input  wire logic [tlf_pkg::BYTE_W-1:0]    req_in_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [tlf_pkg::BYTE_W-1:0]         rsp_out_byte,
   output logic                               rsp_last_of_run,
   input  wire logic                          csr_write,
   input  wire logic [tlf_pkg::CFG_W-1:0]     csr_fold_width
);

   localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
   localparam int unsigned FW = tlf_pkg::CFG_W + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
   localparam logic [FW-1:0] DEPTH_F = FW'(BUFFER_DEPTH);

   typedef enum logic [1:0] {
      FIN_CLEAR = 2'b01,
      FIN_SHIFT = 2'b10
   } fin_type;

   // ring buffer address: logical index j counted from head, wrapped once
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] j);
      logic [CW:0] sum;
      sum = (CW+1)'(head) + (CW+1)'(j);
      if (sum >= (CW+1)'(BUFFER_DEPTH)) begin
         sum = sum - (CW+1)'(BUFFER_DEPTH);
      end
      return AW'(sum);
   endfunction

   logic [tlf_pkg::CFG_W-1:0] fold_width_ff, fold_width_in;
   logic [CW-1:0]             fill_ff, fill_in;
   logic [AW-1:0]             head_ff, head_in;
   logic                      found_ff, found_in;
   logic [AW-1:0]             last_pos_ff, last_pos_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic [CW-1:0]             end_ff, end_in;
   fin_type                   fin_ff, fin_in;
   logic                      skip_ff, skip_in;
   logic                      pend_ff, pend_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [tlf_pkg::BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic [tlf_pkg::BYTE_W-1:0] mem [BUFFER_DEPTH];
   logic [tlf_pkg::BYTE_W-1:0] rd_data_ff;
   logic                       we, re;
   logic [AW-1:0]              wa, ra;

   logic [tlf_pkg::CFG_W-1:0] fw_nz;
   logic [FW-1:0]             fw_ext;
   logic [CW-1:0]             w;
   logic [CW-1:0]             fill_c;
   logic [CW-1:0]             fill_new;
   logic                      room, blank_new, stale, is_end, is_nl;
   logic                      out_free, drop, consume, issue, nl_load;

   // effective width: zero acts as one, capped at the buffer depth
   always_comb begin
      fw_nz  = (fold_width_ff == '0) ? tlf_pkg::CFG_W'(1) : fold_width_ff;
      fw_ext = FW'(fw_nz);
      w      = (fw_ext > DEPTH_F) ? CW'(DEPTH_F) : CW'(fw_ext);
   end

   // request decode and fill bookkeeping
   always_comb begin
      fill_c    = (fill_ff > w) ? w : fill_ff;
      is_end    = (req_command == tlf_pkg::CMD_END);
      is_nl     = !is_end && (req_in_byte == tlf_pkg::CH_NL);
      room      = (fill_c < DEPTH_C);
      fill_new  = fill_c + CW'(room);
      blank_new = tlf_pkg::is_blank(req_in_byte) && (fill_c < w);
      stale     = found_ff && (CW'(last_pos_ff) >= w);
   end

   // read pipe and output handshake
   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      drop     = skip_ff && tlf_pkg::is_blank(rd_data_ff);
      consume  = pend_ff && (drop || out_free);
      issue    = cmd.emit && (idx_ff != end_ff) && (!pend_ff || consume);
      nl_load  = cmd.term && !pend_ff && out_free;
   end

   always_comb begin
      fold_width_in = fold_width_ff;
      fill_in       = fill_ff;
      head_in       = head_ff;
      found_in      = found_ff;
      last_pos_in   = last_pos_ff;
      idx_in        = idx_ff;
      end_in        = end_ff;
      fin_in        = fin_ff;
      skip_in       = skip_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      we            = 1'b0;
      wa            = phys(head_ff, fill_c);
      re            = 1'b0;
      ra            = phys(head_ff, idx_ff);
      sts           = '0;

      if (csr_write) begin
         fold_width_in = csr_fold_width;
      end

      // take a request: store text, or open a span to emit
      if (cmd.take) begin
         if (is_end || is_nl) begin
            if (is_nl || (fill_c != '0)) begin
               end_in      = fill_c;
               fin_in      = FIN_CLEAR;
               idx_in      = '0;
               skip_in     = 1'b1;
               sts.go_emit = 1'b1;
            end else begin
               fill_in  = '0;
               found_in = 1'b0;
            end
         end else begin
            we = room;
            if (fill_new >= w) begin
               if (blank_new) begin
                  end_in      = fill_c;
                  fin_in      = FIN_SHIFT;
                  idx_in      = '0;
                  skip_in     = 1'b1;
                  sts.go_emit = 1'b1;
               end else if (found_ff && !stale) begin
                  end_in      = CW'(last_pos_ff);
                  fin_in      = FIN_SHIFT;
                  idx_in      = '0;
                  skip_in     = 1'b1;
                  sts.go_emit = 1'b1;
               end else if (found_ff) begin
                  idx_in      = w - CW'(1);
                  sts.go_scan = 1'b1;
               end else begin
                  end_in      = w;
                  fin_in      = FIN_CLEAR;
                  idx_in      = '0;
                  skip_in     = 1'b1;
                  sts.go_emit = 1'b1;
               end
            end else begin
               fill_in = fill_new;
               if (blank_new) begin
                  found_in    = 1'b1;
                  last_pos_in = AW'(fill_c);
               end
            end
         end
      end

      // walk back over the segment for its last blank below the width
      if (cmd.scan_rd) begin
         re = 1'b1;
      end
      if (cmd.scan_chk) begin
         if (tlf_pkg::is_blank(rd_data_ff)) begin
            sts.scan_hit = 1'b1;
            end_in       = idx_ff;
            fin_in       = FIN_SHIFT;
            idx_in       = '0;
            skip_in      = 1'b1;
         end else if (idx_ff == '0) begin
            sts.scan_end = 1'b1;
            end_in       = w;
            fin_in       = FIN_CLEAR;
            idx_in       = '0;
            skip_in      = 1'b1;
         end else begin
            idx_in = idx_ff - CW'(1);
         end
      end

      // issue span reads, one per cycle while the output keeps up
      sts.span_issued = (idx_ff == end_ff);
      if (issue) begin
         re     = 1'b1;
         idx_in = idx_ff + CW'(1);
      end

      // drain read data: drop leading blanks, load the rest
      if (issue) begin
         pend_in = 1'b1;
      end else if (consume) begin
         pend_in = 1'b0;
      end
      if (consume && !drop) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = rd_data_ff;
         rsp_last_in  = 1'b0;
         skip_in      = 1'b0;
      end

      // close the span with a newline and settle the segment
      if (nl_load) begin
         sts.nl_done  = 1'b1;
         rsp_valid_in = 1'b1;
         rsp_byte_in  = tlf_pkg::CH_NL;
         rsp_last_in  = 1'b1;
         found_in     = 1'b0;
         unique case (fin_ff)
            FIN_SHIFT: begin
               head_in = phys(head_ff, end_ff + CW'(1));
               fill_in = w - end_ff - CW'(1);
            end
            FIN_CLEAR: begin
               fill_in = '0;
            end
            default: begin
               fill_in = '0;
            end
         endcase
      end
   end

   // segment buffer with registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= req_in_byte;
      end
      if (re) begin
         rd_data_ff <= mem[ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_width_ff <= tlf_pkg::FOLD_WIDTH_RESET;
         fill_ff       <= '0;
         head_ff       <= '0;
         found_ff      <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skip_ff       <= 1'b0;
      end else begin
         fold_width_ff <= fold_width_in;
         fill_ff       <= fill_in;
         head_ff       <= head_in;
         found_ff      <= found_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         skip_ff       <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      last_pos_ff <= last_pos_in;
      idx_ff      <= idx_in;
      end_ff      <= end_in;
      fin_ff      <= fin_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // fill never passes the buffer depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_C)
      else $error("segment fill beyond buffer depth");

   // a tracked blank always lies inside the held segment
   a_blank_inside: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (CW'(last_pos_ff) < fill_ff))
      else $error("tracked blank outside segment");

   // the closing newline comes only after every span read was issued
   a_term_done: assert property (@(posedge clock) disable iff (reset)
      cmd.term |-> (idx_ff == end_ff))
      else $error("newline stage entered with reads outstanding");

   // read data is pending only while a span is being emitted
   a_pend_scope: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (cmd.emit || cmd.term))
      else $error("read data pending outside a span");

   // the last byte of a run is always the newline
   a_last_nl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_byte_ff == tlf_pkg::CH_NL))
      else $error("run ends on a byte other than newline");

endmodule

`default_nettype wire
